### hw/rtl/aes_tbc_pkg.sv
`default_nettype none
package aes_tbc_pkg;

  localparam int NumRounds = 10;
  localparam int BlockW    = 128;
  localparam int HalfW     = 64;

  typedef logic [7:0] byte_t;
  typedef logic [BlockW-1:0] block_t;

  typedef enum logic [1:0] {
    OP_ENC    = 2'd0,
    OP_DEC    = 2'd1,
    OP_TW_ENC = 2'd2,
    OP_TW_DEC = 2'd3
  } op_t;

  localparam logic [0:0] CFG_KEY_HIGH = 1'b0;
  localparam logic [0:0] CFG_KEY_LOW  = 1'b1;

  // per-stage side info that travels with each item
  typedef struct packed {
    logic   vld;
    logic   dec;
    block_t tw;
  } stage_ctl_t;

  localparam byte_t RCON [NumRounds] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  localparam byte_t SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam byte_t ISBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // byte i of a block sits at bits [127-8i -: 8]
  function automatic byte_t get_b(block_t s, int i);
    return s[BlockW-1-8*i -: 8];
  endfunction

  function automatic byte_t xt(byte_t a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic byte_t gmul(byte_t a, logic [3:0] b);
    byte_t p;
    byte_t x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) p = p ^ x;
      x = xt(x);
    end
    return p;
  endfunction

  function automatic block_t sub_shift(block_t s);
    block_t t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[BlockW-1-8*(r+4*c) -: 8] = SBOX[get_b(s, r + 4*((c+r) % 4))];
    return t;
  endfunction

  function automatic block_t inv_shift_sub(block_t s);
    block_t t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[BlockW-1-8*(r+4*((c+r) % 4)) -: 8] = ISBOX[get_b(s, r + 4*c)];
    return t;
  endfunction

  function automatic block_t mix(block_t s, logic inv);
    block_t t;
    byte_t a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = get_b(s, 4*c);
      a1 = get_b(s, 4*c+1);
      a2 = get_b(s, 4*c+2);
      a3 = get_b(s, 4*c+3);
      if (!inv) begin
        t[BlockW-1-8*(4*c)   -: 8] = gmul(a0,4'd2) ^ gmul(a1,4'd3) ^ a2 ^ a3;
        t[BlockW-1-8*(4*c+1) -: 8] = a0 ^ gmul(a1,4'd2) ^ gmul(a2,4'd3) ^ a3;
        t[BlockW-1-8*(4*c+2) -: 8] = a0 ^ a1 ^ gmul(a2,4'd2) ^ gmul(a3,4'd3);
        t[BlockW-1-8*(4*c+3) -: 8] = gmul(a0,4'd3) ^ a1 ^ a2 ^ gmul(a3,4'd2);
      end else begin
        t[BlockW-1-8*(4*c)   -: 8] = gmul(a0,4'd14) ^ gmul(a1,4'd11) ^ gmul(a2,4'd13) ^ gmul(a3,4'd9);
        t[BlockW-1-8*(4*c+1) -: 8] = gmul(a0,4'd9) ^ gmul(a1,4'd14) ^ gmul(a2,4'd11) ^ gmul(a3,4'd13);
        t[BlockW-1-8*(4*c+2) -: 8] = gmul(a0,4'd13) ^ gmul(a1,4'd9) ^ gmul(a2,4'd14) ^ gmul(a3,4'd11);
        t[BlockW-1-8*(4*c+3) -: 8] = gmul(a0,4'd11) ^ gmul(a1,4'd13) ^ gmul(a2,4'd9) ^ gmul(a3,4'd14);
      end
    end
    return t;
  endfunction

  // one step of the AES-128 key schedule
  function automatic block_t key_step(block_t k, byte_t rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage
`default_nettype wire

### hw/rtl/aes_tbc_keysched.sv
`default_nettype none
module aes_tbc_keysched (
  input  wire logic                 clk,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_idx,
  input  wire logic [63:0]          cfg_data,
  input  wire logic                 rst_n,
  output logic [aes_tbc_pkg::BlockW*(aes_tbc_pkg::NumRounds+1)-1:0] rk
);
  import aes_tbc_pkg::*;

  logic [HalfW-1:0] key_hi_r, key_lo_r;
  block_t rk_r [NumRounds+1];
  logic [3:0] step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_KEY_HIGH: key_hi_r <= cfg_data;
        CFG_KEY_LOW:  key_lo_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // expand one round key per cycle; restart on every key write
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      step_r <= '0;
    end else if (step_r != 4'(NumRounds)) begin
      step_r <= step_r + 4'd1;
    end
  end

  // take round key 1 from the key registers, since rk_r[0] is only a registered copy of them
  always_ff @(posedge clk) begin
    rk_r[0] <= {key_hi_r, key_lo_r};
    for (int i = 1; i <= NumRounds; i++) begin
      if (step_r == 4'(i - 1))
        rk_r[i] <= key_step((i == 1) ? {key_hi_r, key_lo_r} : rk_r[i-1], RCON[i-1]);
    end
  end

  always_comb begin
    for (int i = 0; i <= NumRounds; i++) rk[BlockW*i +: BlockW] = rk_r[i];
  end
endmodule
`default_nettype wire

### hw/rtl/aes_tbc_round.sv
`default_nettype none
module aes_tbc_round (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire aes_tbc_pkg::stage_ctl_t ctl_in,
  input  wire aes_tbc_pkg::block_t     st_in,
  input  wire aes_tbc_pkg::block_t     rk_enc,
  input  wire aes_tbc_pkg::block_t     rk_dec,
  input  wire logic                    last,
  output aes_tbc_pkg::stage_ctl_t      ctl_out,
  output aes_tbc_pkg::block_t          st_out
);
  import aes_tbc_pkg::*;

  stage_ctl_t ctl_r;
  block_t st_r, st_nxt, e, d;

  always_comb begin
    e = sub_shift(st_in);
    if (!last) e = mix(e, 1'b0);
    e = e ^ rk_enc ^ ctl_in.tw;
    d = inv_shift_sub(st_in) ^ rk_dec ^ ctl_in.tw;
    if (!last) d = mix(d, 1'b1);
    st_nxt = ctl_in.dec ? d : e;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ctl_r.vld <= 1'b0;
    else        ctl_r.vld <= ctl_in.vld;
    ctl_r.dec <= ctl_in.dec;
    ctl_r.tw  <= ctl_in.tw;
    st_r      <= st_nxt;
  end

  assign ctl_out = ctl_r;
  assign st_out  = st_r;
endmodule
`default_nettype wire

### hw/rtl/aes128_tweakable_block_cipher.sv
// Channel | Ports                                   | Handshake
// input   | in_op, in_data_high/low, in_tweak       | start & !busy
// result  | out_result_high/low                     | out_valid, one cycle
// config  | cfg_we, cfg_idx, cfg_data               | cfg_we
// One item enters per cycle while busy is low; each result is registered in
// the input stage and then in one register per round stage.
// busy is high after reset or a key write while the key schedule expands
// one round key per cycle.
// rst_n is synchronous and clears valid bits and the key registers.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none
module aes128_tweakable_block_cipher (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_op,
  input  wire logic [63:0] in_data_high,
  input  wire logic [63:0] in_data_low,
  input  wire logic [63:0] in_tweak,
  output logic             out_valid,
  output logic [63:0]      out_result_high,
  output logic [63:0]      out_result_low,
  input  wire logic        cfg_we,
  input  wire logic        cfg_idx,
  input  wire logic [63:0] cfg_data
);
  import aes_tbc_pkg::*;

  logic [BlockW*(NumRounds+1)-1:0] rk;
  logic [3:0] warm_r;
  stage_ctl_t ctl [NumRounds+1];
  block_t st [NumRounds+1];
  stage_ctl_t ctl0_r;
  block_t st0_r, tw, st0_nxt;

  aes_tbc_keysched u_ks (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_data, .rk
  );

  // hold off items until the round keys are complete
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) warm_r <= 4'(NumRounds + 1);
    else if (warm_r != 4'd0) warm_r <= warm_r - 4'd1;
  end
  assign busy = (warm_r != 4'd0);

  always_comb begin
    tw = '0;
    if (in_op[1]) begin
      for (int i = 0; i < 4; i++) tw[BlockW-1-32*i -: 16] = in_tweak[HalfW-1-16*i -: 16];
    end
    st0_nxt = {in_data_high, in_data_low} ^ tw ^
              (in_op[0] ? rk[BlockW*NumRounds +: BlockW] : rk[0 +: BlockW]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ctl0_r.vld <= 1'b0;
    else        ctl0_r.vld <= start && !busy;
    ctl0_r.dec <= in_op[0];
    ctl0_r.tw  <= tw;
    st0_r      <= st0_nxt;
  end

  assign ctl[0] = ctl0_r;
  assign st[0]  = st0_r;

  for (genvar g = 1; g <= NumRounds; g++) begin : g_rnd
    aes_tbc_round u_rnd (
      .clk, .rst_n,
      .ctl_in (ctl[g-1]),
      .st_in  (st[g-1]),
      .rk_enc (rk[BlockW*g +: BlockW]),
      .rk_dec (rk[BlockW*(NumRounds-g) +: BlockW]),
      .last   (g == NumRounds),
      .ctl_out(ctl[g]),
      .st_out (st[g])
    );
  end

  assign out_valid       = ctl[NumRounds].vld;
  assign out_result_high = st[NumRounds][BlockW-1:HalfW];
  assign out_result_low  = st[NumRounds][HalfW-1:0];
endmodule
`default_nettype wire

### hw/rtl/aes_tbc_checker.sv
`default_nettype none
module aes_tbc_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid,
  input wire logic cfg_we
);
  // a key write blocks items on the next cycle
  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> busy) else $error("busy not raised after key write");
  // no result appears without an item accepted earlier at the input
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 11)) else $error("unexpected result");
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##11 out_valid) else $error("result lost");
endmodule

bind aes128_tweakable_block_cipher aes_tbc_checker u_chk (
  .clk, .rst_n, .start, .busy, .out_valid, .cfg_we
);
`default_nettype wire
